// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the shader RTL.
// Every macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define DNMS_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// Checks that a trigger is followed by a condition on the next edge.
`define DNMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dnms_pkg.sv =====
package dnms_pkg;

  // Default map store geometry.
  localparam int MAX_MAP_WIDTH  = 128;
  localparam int MAX_MAP_HEIGHT = 64;

  // Result queue depth; it also bounds the shade items in flight.
  localparam int FIFO_DEPTH = 8;

  // Configuration port.
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // Stream payload widths.
  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;
  localparam int TEXEL_W    = 24;

  // Item operations.
  localparam logic [1:0] OP_WRITE_DAY   = 2'd0;
  localparam logic [1:0] OP_WRITE_NIGHT = 2'd1;
  localparam logic [1:0] OP_SHADE       = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_USE_NIGHT  = 3'd0;
  localparam logic [2:0] REG_DAWN_WIDTH = 3'd1;
  localparam logic [2:0] REG_AMBIENT    = 3'd2;
  localparam logic [2:0] REG_MAP_WIDTH  = 3'd3;
  localparam logic [2:0] REG_MAP_HEIGHT = 3'd4;

  // Register reset values.
  localparam logic       RST_USE_NIGHT  = 1'b1;
  localparam logic [8:0] RST_DAWN_WIDTH = 9'd64;
  localparam logic [8:0] RST_AMBIENT    = 9'd128;
  localparam logic [7:0] RST_MAP_WIDTH  = 8'd128;
  localparam logic [6:0] RST_MAP_HEIGHT = 7'd64;

  // Configuration after saturation, as the datapath uses it.
  typedef struct packed {
    logic       use_night;
    logic [8:0] dawn;
    logic [8:0] amb;
    logic [7:0] width;
    logic [6:0] height;
  } cfg_t;

  // Per-sample control handed from the address pipeline to the filter.
  typedef struct packed {
    logic              valid;
    logic [7:0]        dx;
    logic [7:0]        dy;
    logic signed [9:0] ang;
  } shade_ctl_t;

  // One interpolation step: a + floor((b - a) * f / 256).
  function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] f);
    logic signed [8:0]  diff;
    logic signed [17:0] prod;
    logic signed [9:0]  step;
    logic signed [9:0]  sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, f});
    step = 10'(prod >>> 8);
    sum  = $signed({2'b00, a}) + step;
    return sum[7:0];
  endfunction

endpackage

// ===== sv/dnms_texel_ram.sv =====
module dnms_texel_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13,
  parameter int DW    = 24
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr0_i,
  input  logic [AW-1:0] raddr1_i,
  output logic [DW-1:0] rdata0_o,
  output logic [DW-1:0] rdata1_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata0_q;
  logic [DW-1:0] rdata1_q;

  // One write port and two registered read ports; a read of the entry
  // being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata0_q <= mem[raddr0_i];
    rdata1_q <= mem[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// ===== sv/dnms_addr_gen.sv =====
`include "assert_macros.svh"

module dnms_addr_gen #(
  parameter int MAX_W = dnms_pkg::MAX_MAP_WIDTH,
  parameter int MAX_H = dnms_pkg::MAX_MAP_HEIGHT,
  localparam int DEPTH = MAX_W * MAX_H,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [1:0]             in_op_i,
  input  logic [12:0]            in_addr_i,
  input  logic [23:0]            in_color_i,
  input  logic [15:0]            in_lon_i,
  input  logic signed [15:0]     in_lat_i,
  input  logic signed [9:0]      in_cos_i,
  input  dnms_pkg::cfg_t         cfg_i,
  output logic                   day_we_o,
  output logic                   night_we_o,
  output logic [AW-1:0]          wr_addr_o,
  output logic [23:0]            wr_data_o,
  output logic [AW-1:0]          rd_addr0_o,
  output logic [AW-1:0]          rd_addr1_o,
  output dnms_pkg::shade_ctl_t   ctl_o
);

  localparam int XW = $clog2(MAX_W);
  localparam int YW = $clog2(MAX_H);
  localparam int PW = YW + 8;

  // Stage 1: the accepted item.
  logic                v1_q;
  logic [1:0]          op1_q;
  logic [12:0]         addr1_q;
  logic [23:0]         color1_q;
  logic [15:0]         lon1_q;
  logic signed [15:0]  lat1_q;
  logic signed [9:0]   cos1_q;

  // Stage 2: scaled positions and the twilight product.
  logic                v2_q;
  logic [1:0]          op2_q;
  logic [12:0]         addr2_q;
  logic [23:0]         color2_q;
  logic [7:0]          xf2_q;
  logic [6:0]          yf2_q;
  logic [7:0]          dx2_q;
  logic [7:0]          dy2_q;
  logic signed [9:0]   cosc2_q;
  logic [16:0]         m2_q;

  // Stage 3: wrapped neighbor columns and rows, light weight.
  logic                v3_q;
  logic [1:0]          op3_q;
  logic [12:0]         addr3_q;
  logic [23:0]         color3_q;
  logic [XW-1:0]       x0_3_q;
  logic [XW-1:0]       x1_3_q;
  logic [YW-1:0]       y0_3_q;
  logic [YW-1:0]       y1_3_q;
  logic [7:0]          dx3_q;
  logic [7:0]          dy3_q;
  logic signed [9:0]   ang3_q;

  // Stage 4: row bases; first-row reads and texel writes issue here.
  logic                v4_q;
  logic [1:0]          op4_q;
  logic [12:0]         addr4_q;
  logic [23:0]         color4_q;
  logic [XW-1:0]       x0_4_q;
  logic [XW-1:0]       x1_4_q;
  logic [AW-1:0]       r0_4_q;
  logic [AW-1:0]       r1_4_q;
  logic [7:0]          dx4_q;
  logic [7:0]          dy4_q;
  logic signed [9:0]   ang4_q;

  // Stage 5: second-row reads issue here.
  logic                sh5_q;
  logic [XW-1:0]       x0_5_q;
  logic [XW-1:0]       x1_5_q;
  logic [AW-1:0]       r1_5_q;
  logic [7:0]          dx5_q;
  logic [7:0]          dy5_q;
  logic signed [9:0]   ang5_q;

  logic [15:0]         lon_u;
  logic [23:0]         xprod;
  logic signed [15:0]  lat_c;
  logic [15:0]         lat_p;
  logic [22:0]         yprod;
  logic signed [9:0]   cos_c;
  logic [9:0]          cos_rem;
  logic [16:0]         m_d;

  logic [6:0]          y0_full;
  logic [7:0]          y1_full;
  logic [8:0]          x1_full;
  logic [17:0]         ang_sum;
  logic [9:0]          ang_dim;
  logic signed [9:0]   ang_d;

  logic [PW-1:0]       r0_full;
  logic [PW-1:0]       r1_full;

  logic                sh4;
  logic                in_range4;

  // Position scaling and input saturation.
  always_comb begin
    lon_u   = lon1_q + 16'h8000;
    xprod   = 24'(lon_u) * 24'(cfg_i.width);
    lat_c   = lat1_q;
    if (lat1_q < -16'sd16384) begin
      lat_c = -16'sd16384;
    end else if (lat1_q > 16'sd16384) begin
      lat_c = 16'sd16384;
    end
    lat_p   = 16'(lat_c + 16'sd16384);
    yprod   = 23'(lat_p) * 23'(cfg_i.height);
    cos_c   = cos1_q;
    if (cos1_q < -10'sd256) begin
      cos_c = -10'sd256;
    end else if (cos1_q > 10'sd256) begin
      cos_c = 10'sd256;
    end
    cos_rem = 10'd256 - 10'(cos_c);
    m_d     = 17'(cos_rem[8:0]) * 17'(cfg_i.dawn);
  end

  // Edge wrapping and the dawn-shaped light weight.
  always_comb begin
    y0_full = (yf2_q == cfg_i.height) ? 7'd0 : yf2_q;
    y1_full = (8'(y0_full) + 8'd1 == 8'(cfg_i.height)) ? 8'd0 : 8'(y0_full) + 8'd1;
    x1_full = (9'(xf2_q) + 9'd1 == 9'(cfg_i.width)) ? 9'd0 : 9'(xf2_q) + 9'd1;
    ang_sum = 18'(m2_q) + 18'd255;
    ang_dim = 10'd256 - 10'(ang_sum[17:8]);
    ang_d   = (cosc2_q > 10'sd0) ? $signed(ang_dim) : cosc2_q;
  end

  // Row base addresses.
  always_comb begin
    r0_full = PW'(y0_3_q) * PW'(cfg_i.width);
    r1_full = PW'(y1_3_q) * PW'(cfg_i.width);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      sh5_q <= 1'b0;
    end else begin
      v1_q  <= in_valid_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      sh5_q <= sh4;
    end
  end

  // Payload registers move every cycle; the valid bits qualify them.
  always_ff @(posedge clk_i) begin
    op1_q    <= in_op_i;
    addr1_q  <= in_addr_i;
    color1_q <= in_color_i;
    lon1_q   <= in_lon_i;
    lat1_q   <= in_lat_i;
    cos1_q   <= in_cos_i;

    op2_q    <= op1_q;
    addr2_q  <= addr1_q;
    color2_q <= color1_q;
    xf2_q    <= xprod[23:16];
    dx2_q    <= xprod[15:8];
    yf2_q    <= yprod[21:15];
    dy2_q    <= yprod[14:7];
    cosc2_q  <= cos_c;
    m2_q     <= m_d;

    op3_q    <= op2_q;
    addr3_q  <= addr2_q;
    color3_q <= color2_q;
    x0_3_q   <= XW'(xf2_q);
    x1_3_q   <= XW'(x1_full);
    y0_3_q   <= YW'(y0_full);
    y1_3_q   <= YW'(y1_full);
    dx3_q    <= dx2_q;
    dy3_q    <= dy2_q;
    ang3_q   <= ang_d;

    op4_q    <= op3_q;
    addr4_q  <= addr3_q;
    color4_q <= color3_q;
    x0_4_q   <= x0_3_q;
    x1_4_q   <= x1_3_q;
    r0_4_q   <= AW'(r0_full);
    r1_4_q   <= AW'(r1_full);
    dx4_q    <= dx3_q;
    dy4_q    <= dy3_q;
    ang4_q   <= ang3_q;

    x0_5_q   <= x0_4_q;
    x1_5_q   <= x1_4_q;
    r1_5_q   <= r1_4_q;
    dx5_q    <= dx4_q;
    dy5_q    <= dy4_q;
    ang5_q   <= ang4_q;
  end

  // Writes take effect in stage 4, in item order with the reads.
  assign sh4       = v4_q && (op4_q == dnms_pkg::OP_SHADE);
  assign in_range4 = 32'(addr4_q) < 32'(DEPTH);
  assign day_we_o   = v4_q && (op4_q == dnms_pkg::OP_WRITE_DAY) && in_range4;
  assign night_we_o = v4_q && (op4_q == dnms_pkg::OP_WRITE_NIGHT) && in_range4;
  assign wr_addr_o  = AW'(addr4_q);
  assign wr_data_o  = color4_q;

  // The read ports serve the first row in stage 4 and the second in stage 5.
  assign rd_addr0_o = sh4 ? AW'(r0_4_q + AW'(x0_4_q)) : AW'(r1_5_q + AW'(x0_5_q));
  assign rd_addr1_o = sh4 ? AW'(r0_4_q + AW'(x1_4_q)) : AW'(r1_5_q + AW'(x1_5_q));

  assign ctl_o.valid = sh5_q;
  assign ctl_o.dx    = dx5_q;
  assign ctl_o.dy    = dy5_q;
  assign ctl_o.ang   = ang5_q;

  `DNMS_ASSERT(a_read_ports_single_use, !(sh4 && sh5_q), "both read rows issued at once")

endmodule

// ===== sv/dnms_filter.sv =====
module dnms_filter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dnms_pkg::shade_ctl_t ctl_i,
  input  dnms_pkg::cfg_t       cfg_i,
  input  logic [23:0]          day0_i,
  input  logic [23:0]          day1_i,
  input  logic [23:0]          night0_i,
  input  logic [23:0]          night1_i,
  output logic                 push_o,
  output logic [23:0]          pixel_o
);

  // Stage 6: top row interpolated along x.
  logic               v6_q;
  logic [7:0]         dx6_q;
  logic [7:0]         dy6_q;
  logic signed [9:0]  ang6_q;
  logic [7:0]         tday6_q [3];
  logic [7:0]         tnight6_q [3];

  // Stage 7: both rows interpolated along x.
  logic               v7_q;
  logic [7:0]         dy7_q;
  logic signed [9:0]  ang7_q;
  logic [7:0]         tday7_q [3];
  logic [7:0]         tnight7_q [3];
  logic [7:0]         bday7_q [3];
  logic [7:0]         bnight7_q [3];

  // Stage 8: finished bilinear samples.
  logic               v8_q;
  logic signed [9:0]  ang8_q;
  logic [7:0]         sday8_q [3];
  logic [7:0]         snight8_q [3];

  // Stage 9: blend products.
  logic               v9_q;
  logic               angpos9_q;
  logic [16:0]        p1_9_q [3];
  logic [16:0]        p2_9_q [3];
  logic [7:0]         n9_q [3];

  logic [7:0]         fx;
  logic [7:0]         hday [3];
  logic [7:0]         hnight [3];
  logic [7:0]         vday [3];
  logic [7:0]         vnight [3];
  logic [9:0]         inv_ang;
  logic [9:0]         inv_amb;
  logic [16:0]        p1 [3];
  logic [16:0]        p2 [3];
  logic [16:0]        amb_term [3];
  logic [17:0]        mix [3];
  logic [7:0]         res [3];

  // One set of x lerps serves the top row and, in the next cycle, the bottom row.
  always_comb begin
    fx = v6_q ? dx6_q : ctl_i.dx;
    for (int k = 0; k < 3; k++) begin
      hday[k]   = dnms_pkg::lerp8(day0_i[23-8*k -: 8], day1_i[23-8*k -: 8], fx);
      hnight[k] = dnms_pkg::lerp8(night0_i[23-8*k -: 8], night1_i[23-8*k -: 8], fx);
      vday[k]   = dnms_pkg::lerp8(tday7_q[k], bday7_q[k], dy7_q);
      vnight[k] = dnms_pkg::lerp8(tnight7_q[k], bnight7_q[k], dy7_q);
    end
  end

  // Blend products: night weighting, or ambient scaling of the day sample.
  always_comb begin
    inv_ang = 10'd256 - 10'(ang8_q);
    for (int k = 0; k < 3; k++) begin
      p1[k] = cfg_i.use_night ? 17'(snight8_q[k]) * 17'(inv_ang[8:0])
                              : 17'(sday8_q[k]) * 17'(cfg_i.amb);
      p2[k] = 17'(sday8_q[k]) * 17'(ang8_q[8:0]);
    end
  end

  // Final sum per channel.
  always_comb begin
    inv_amb = 10'd256 - 10'(cfg_i.amb);
    for (int k = 0; k < 3; k++) begin
      amb_term[k] = 17'(p2_9_q[k][15:8]) * 17'(inv_amb[8:0]);
      if (cfg_i.use_night) begin
        mix[k] = 18'(p1_9_q[k]) + 18'(p2_9_q[k]);
        res[k] = angpos9_q ? mix[k][15:8] : n9_q[k];
      end else begin
        mix[k] = 18'(p1_9_q[k]) + 18'(amb_term[k]);
        res[k] = angpos9_q ? mix[k][15:8] : p1_9_q[k][15:8];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else begin
      v6_q <= ctl_i.valid;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx6_q     <= ctl_i.dx;
    dy6_q     <= ctl_i.dy;
    ang6_q    <= ctl_i.ang;
    dy7_q     <= dy6_q;
    ang7_q    <= ang6_q;
    ang8_q    <= ang7_q;
    angpos9_q <= ang8_q > 10'sd0;
    for (int k = 0; k < 3; k++) begin
      tday6_q[k]   <= hday[k];
      tnight6_q[k] <= hnight[k];
      tday7_q[k]   <= tday6_q[k];
      tnight7_q[k] <= tnight6_q[k];
      bday7_q[k]   <= hday[k];
      bnight7_q[k] <= hnight[k];
      sday8_q[k]   <= vday[k];
      snight8_q[k] <= vnight[k];
      p1_9_q[k]    <= p1[k];
      p2_9_q[k]    <= p2[k];
      n9_q[k]      <= snight8_q[k];
    end
  end

  // Red goes to the lowest byte of the result.
  assign push_o  = v9_q;
  assign pixel_o = {res[2], res[1], res[0]};

endmodule

// ===== sv/dnms_out_fifo.sv =====
`include "assert_macros.svh"

module dnms_out_fifo #(
  parameter int DEPTH = dnms_pkg::FIFO_DEPTH,
  parameter int DW    = dnms_pkg::OUT_DATA_W,
  localparam int PW   = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [DW-1:0] data_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr_q;
  logic [PW-1:0] wr_ptr_d;
  logic [PW-1:0] rd_ptr_q;
  logic [PW-1:0] rd_ptr_d;
  logic [CW-1:0] count_q;
  logic [CW-1:0] count_d;
  logic          pop;

  assign valid_o = count_q != '0;
  assign pop     = valid_o && ready_i;
  assign data_o  = mem[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop) begin
      count_d = count_q + CW'(1);
    end else if (pop && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

  `DNMS_ASSERT(a_no_overflow, !(push_i && count_q == CW'(DEPTH)), "result pushed into a full queue")

endmodule

// ===== sv/day_night_map_shader_top.sv =====
// Day/night map shader.
// Input stream (s_axis): tuser carries the operation (write day texel, write night
// texel, shade sample); tdata carries address, color, longitude, latitude and light.
// Write transactions load the two texel maps and produce no result; a shade
// transaction returns one RGB pixel on the output stream (m_axis).
// The APB port holds five registers at byte addresses 0, 4, 8, 12 and 16; write
// them only while no transaction is in flight.
// A shade result passes the address stages, texel reads, filter stages and the
// output queue before it appears on m_axis. Transactions are not accepted back
// to back: each sample fetches four texels from each map, and each map memory
// has two read ports, so the two rows of the footprint are read in turn.
// Up to eight shade transactions may be in flight or queued. When the receiver
// stalls, results collect in the output queue and s_axis_tready drops once it
// would overflow; no result is lost.
// Reset returns the registers to their defaults and empties the pipeline and
// queue. Map contents are undefined until written.
`include "assert_macros.svh"

module day_night_map_shader_top #(
  parameter int MAX_MAP_WIDTH  = dnms_pkg::MAX_MAP_WIDTH,
  parameter int MAX_MAP_HEIGHT = dnms_pkg::MAX_MAP_HEIGHT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // APB configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dnms_pkg::APB_AW-1:0]      paddr,
  input  logic [dnms_pkg::APB_DW-1:0]      pwdata,
  output logic [dnms_pkg::APB_DW-1:0]      prdata,
  output logic                             pready,
  // Item stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // texel_address[12:0], texel_color[36:13], longitude_turn[52:37],
  // latitude_turn[68:53], light_cosine[78:69], zero[79]
  input  logic [dnms_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // operation[1:0]
  input  logic [dnms_pkg::IN_USER_W-1:0]   s_axis_tuser,
  // Result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // red[7:0], green[15:8], blue[23:16]
  output logic [dnms_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  localparam int DEPTH = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(dnms_pkg::FIFO_DEPTH + 1);

  logic                 use_night_q;
  logic [8:0]           dawn_q;
  logic [8:0]           amb_q;
  logic [7:0]           width_q;
  logic [6:0]           height_q;
  logic                 cfg_wr;
  logic [2:0]           cfg_idx;

  dnms_pkg::cfg_t       cfg;
  dnms_pkg::shade_ctl_t ctl;

  logic                 in_accept;
  logic                 out_accept;
  logic                 acc_last_q;
  logic [CW-1:0]        outstanding_q;
  logic [CW-1:0]        outstanding_d;

  logic                 day_we;
  logic                 night_we;
  logic [AW-1:0]        wr_addr;
  logic [23:0]          wr_data;
  logic [AW-1:0]        rd_addr0;
  logic [AW-1:0]        rd_addr1;
  logic [23:0]          day0;
  logic [23:0]          day1;
  logic [23:0]          night0;
  logic [23:0]          night1;
  logic                 push;
  logic [23:0]          pixel;

  // Register file.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_night_q <= dnms_pkg::RST_USE_NIGHT;
      dawn_q      <= dnms_pkg::RST_DAWN_WIDTH;
      amb_q       <= dnms_pkg::RST_AMBIENT;
      width_q     <= dnms_pkg::RST_MAP_WIDTH;
      height_q    <= dnms_pkg::RST_MAP_HEIGHT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        dnms_pkg::REG_USE_NIGHT:  use_night_q <= pwdata[0];
        dnms_pkg::REG_DAWN_WIDTH: dawn_q      <= pwdata[8:0];
        dnms_pkg::REG_AMBIENT:    amb_q       <= pwdata[8:0];
        dnms_pkg::REG_MAP_WIDTH:  width_q     <= pwdata[7:0];
        dnms_pkg::REG_MAP_HEIGHT: height_q    <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      dnms_pkg::REG_USE_NIGHT:  prdata = 32'(use_night_q);
      dnms_pkg::REG_DAWN_WIDTH: prdata = 32'(dawn_q);
      dnms_pkg::REG_AMBIENT:    prdata = 32'(amb_q);
      dnms_pkg::REG_MAP_WIDTH:  prdata = 32'(width_q);
      dnms_pkg::REG_MAP_HEIGHT: prdata = 32'(height_q);
      default:                  prdata = '0;
    endcase
  end

  // Saturated register values as the datapath sees them.
  always_comb begin
    cfg.use_night = use_night_q;
    cfg.dawn      = (dawn_q > 9'd256) ? 9'd256 : dawn_q;
    cfg.amb       = (amb_q > 9'd256) ? 9'd256 : amb_q;
    if (width_q == 8'd0) begin
      cfg.width = 8'd1;
    end else if (32'(width_q) > 32'(MAX_MAP_WIDTH)) begin
      cfg.width = 8'(MAX_MAP_WIDTH);
    end else begin
      cfg.width = width_q;
    end
    if (height_q == 7'd0) begin
      cfg.height = 7'd1;
    end else if (32'(height_q) > 32'(MAX_MAP_HEIGHT)) begin
      cfg.height = 7'(MAX_MAP_HEIGHT);
    end else begin
      cfg.height = height_q;
    end
  end

  // Input admission: never back to back, and only with room in the result queue.
  assign s_axis_tready = !acc_last_q && (outstanding_q < CW'(dnms_pkg::FIFO_DEPTH));
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_accept    = m_axis_tvalid && m_axis_tready;

  always_comb begin
    outstanding_d = outstanding_q;
    if (in_accept && (s_axis_tuser == dnms_pkg::OP_SHADE) && !out_accept) begin
      outstanding_d = outstanding_q + CW'(1);
    end else if (out_accept && !(in_accept && (s_axis_tuser == dnms_pkg::OP_SHADE))) begin
      outstanding_d = outstanding_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_last_q    <= 1'b0;
      outstanding_q <= '0;
    end else begin
      acc_last_q    <= in_accept;
      outstanding_q <= outstanding_d;
    end
  end

  dnms_addr_gen #(
    .MAX_W (MAX_MAP_WIDTH),
    .MAX_H (MAX_MAP_HEIGHT)
  ) u_addr_gen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_accept),
    .in_op_i    (s_axis_tuser),
    .in_addr_i  (s_axis_tdata[12:0]),
    .in_color_i (s_axis_tdata[36:13]),
    .in_lon_i   (s_axis_tdata[52:37]),
    .in_lat_i   ($signed(s_axis_tdata[68:53])),
    .in_cos_i   ($signed(s_axis_tdata[78:69])),
    .cfg_i      (cfg),
    .day_we_o   (day_we),
    .night_we_o (night_we),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_addr0_o (rd_addr0),
    .rd_addr1_o (rd_addr1),
    .ctl_o      (ctl)
  );

  dnms_texel_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (dnms_pkg::TEXEL_W)
  ) u_day_ram (
    .clk_i    (clk_i),
    .we_i     (day_we),
    .waddr_i  (wr_addr),
    .wdata_i  (wr_data),
    .raddr0_i (rd_addr0),
    .raddr1_i (rd_addr1),
    .rdata0_o (day0),
    .rdata1_o (day1)
  );

  dnms_texel_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (dnms_pkg::TEXEL_W)
  ) u_night_ram (
    .clk_i    (clk_i),
    .we_i     (night_we),
    .waddr_i  (wr_addr),
    .wdata_i  (wr_data),
    .raddr0_i (rd_addr0),
    .raddr1_i (rd_addr1),
    .rdata0_o (night0),
    .rdata1_o (night1)
  );

  dnms_filter u_filter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .cfg_i    (cfg),
    .day0_i   (day0),
    .day1_i   (day1),
    .night0_i (night0),
    .night1_i (night1),
    .push_o   (push),
    .pixel_o  (pixel)
  );

  dnms_out_fifo #(
    .DEPTH (dnms_pkg::FIFO_DEPTH),
    .DW    (dnms_pkg::OUT_DATA_W)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (pixel),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata)
  );

  `DNMS_ASSERT(a_credit_bound, outstanding_q <= CW'(dnms_pkg::FIFO_DEPTH), "too many shades in flight")
  `DNMS_ASSERT_NEXT(a_accept_spacing, in_accept, !s_axis_tready, "transactions accepted back to back")

endmodule

// ===== verif/tb_day_night_map_shader_top.sv =====
`timescale 1ns / 100ps

module tb_day_night_map_shader_top;

  localparam int STORE_DEPTH = dnms_pkg::MAX_MAP_WIDTH * dnms_pkg::MAX_MAP_HEIGHT;
  localparam int PHASE_ITEMS = 85;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  // One item of the input stream, field by field.
  typedef struct {
    logic [1:0]         operation;
    logic [12:0]        texel_address;
    logic [23:0]        texel_color;
    logic [15:0]        longitude_turn;
    logic signed [15:0] latitude_turn;
    logic signed [9:0]  light_cosine;
  } shader_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Four neighbor addresses of a sample and its 8-bit fractions.
  typedef struct {
    int unsigned a00;
    int unsigned a01;
    int unsigned a10;
    int unsigned a11;
    int          dx;
    int          dy;
  } footprint_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [dnms_pkg::APB_AW-1:0]       paddr = '0;
  logic [dnms_pkg::APB_DW-1:0]       pwdata = '0;
  logic [dnms_pkg::APB_DW-1:0]       prdata;
  logic                              pready;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  // texel_address, texel_color, longitude_turn, latitude_turn, light_cosine, zero
  logic [dnms_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;
  // operation
  logic [dnms_pkg::IN_USER_W-1:0]    s_axis_tuser = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  // red, green, blue
  logic [dnms_pkg::OUT_DATA_W-1:0]   m_axis_tdata;

  // Shader settings as the predictor sees them.
  logic       cfg_use_night = dnms_pkg::RST_USE_NIGHT;
  logic [8:0] cfg_dawn = dnms_pkg::RST_DAWN_WIDTH;
  logic [8:0] cfg_amb = dnms_pkg::RST_AMBIENT;
  logic [7:0] cfg_width = dnms_pkg::RST_MAP_WIDTH;
  logic [6:0] cfg_height = dnms_pkg::RST_MAP_HEIGHT;

  // Predicted map contents, and which entries the stimulus has already loaded.
  logic [23:0] day_store [STORE_DEPTH];
  logic [23:0] night_store [STORE_DEPTH];
  bit          day_written [STORE_DEPTH];
  bit          night_written [STORE_DEPTH];

  shader_item_t pending_items[$];
  shader_item_t offered_item;
  pixel_t       expected_pixels[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          receiver_hold = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned pixel_count = 0;

  day_night_map_shader_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Map sizes and Q8 levels are saturated before use.
  function automatic int map_cols();
    int w;
    w = cfg_width;
    if (w < 1) w = 1;
    if (w > dnms_pkg::MAX_MAP_WIDTH) w = dnms_pkg::MAX_MAP_WIDTH;
    return w;
  endfunction

  function automatic int map_rows();
    int h;
    h = cfg_height;
    if (h < 1) h = 1;
    if (h > dnms_pkg::MAX_MAP_HEIGHT) h = dnms_pkg::MAX_MAP_HEIGHT;
    return h;
  endfunction

  // Texel position of a sample: longitude turned by half a turn, latitude
  // clamped to the poles, both edges wrapping.
  function automatic footprint_t locate_texels(input logic [15:0] lon_in,
                                               input logic signed [15:0] lat_in);
    footprint_t fp;
    int unsigned w, h, lon, xl, yl, x0, x1, y0, y1;
    int lat;
    w = map_cols();
    h = map_rows();
    lon = (int'(lon_in) + 32768) % 65536;
    lat = lat_in;
    if (lat < -16384) lat = -16384;
    if (lat > 16384) lat = 16384;
    xl = (lon * w) >> 8;
    yl = (unsigned'(lat + 16384) * h) >> 7;
    x0 = (xl >> 8) % w;
    y0 = (yl >> 8) % h;
    x1 = (x0 + 1) % w;
    y1 = (y0 + 1) % h;
    fp.a00 = y0 * w + x0;
    fp.a01 = y0 * w + x1;
    fp.a10 = y1 * w + x0;
    fp.a11 = y1 * w + x1;
    fp.dx = xl & 255;
    fp.dy = yl & 255;
    return fp;
  endfunction

  // a + floor((b - a) * f / 256)
  function automatic int lerp_step(input int a, input int b, input int f);
    return a + (((b - a) * f) >>> 8);
  endfunction

  // Bilinear filter per channel: along x in both rows, then along y.
  function automatic logic [23:0] filter_texels(input logic [23:0] t00, input logic [23:0] t01,
                                                input logic [23:0] t10, input logic [23:0] t11,
                                                input int dx, input int dy);
    logic [23:0] rgb;
    int top, bottom, mid, k;
    for (k = 0; k < 24; k += 8) begin
      top = lerp_step(t00[k+:8], t01[k+:8], dx);
      bottom = lerp_step(t10[k+:8], t11[k+:8], dx);
      mid = lerp_step(top, bottom, dy);
      rgb[k+:8] = mid[7:0];
    end
    return rgb;
  endfunction

  // Expected pixel of a shade transaction under the current settings.
  function automatic pixel_t shade_pixel(input shader_item_t it);
    footprint_t fp;
    logic [23:0] day_rgb, night_rgb, mix;
    pixel_t px;
    int c, ang, dawn, amb, k, d, n, v;
    fp = locate_texels(it.longitude_turn, it.latitude_turn);
    day_rgb = filter_texels(day_store[fp.a00], day_store[fp.a01], day_store[fp.a10],
                            day_store[fp.a11], fp.dx, fp.dy);
    night_rgb = filter_texels(night_store[fp.a00], night_store[fp.a01],
                              night_store[fp.a10], night_store[fp.a11], fp.dx, fp.dy);
    dawn = (cfg_dawn > 256) ? 256 : cfg_dawn;
    amb = (cfg_amb > 256) ? 256 : cfg_amb;
    c = it.light_cosine;
    if (c < -256) c = -256;
    if (c > 256) c = 256;
    // Lit side falls off toward the terminator at a rate set by the dawn width.
    if (c > 0) ang = 256 - (((256 - c) * dawn + 255) >> 8);
    else ang = c;
    for (k = 0; k < 24; k += 8) begin
      d = day_rgb[k+:8];
      n = night_rgb[k+:8];
      if (cfg_use_night) v = (ang > 0) ? (n * (256 - ang) + d * ang) >> 8 : n;
      else if (ang > 0) v = (d * amb + ((d * ang) >> 8) * (256 - amb)) >> 8;
      else v = (d * amb) >> 8;
      mix[k+:8] = v[7:0];
    end
    px.red = mix[23:16];
    px.green = mix[15:8];
    px.blue = mix[7:0];
    return px;
  endfunction

  // Update the predicted state for one accepted transaction.
  function automatic void absorb_item(input shader_item_t it);
    case (it.operation)
      dnms_pkg::OP_WRITE_DAY: day_store[it.texel_address] = it.texel_color;
      dnms_pkg::OP_WRITE_NIGHT: night_store[it.texel_address] = it.texel_color;
      dnms_pkg::OP_SHADE: expected_pixels.push_back(shade_pixel(it));
      default: ;
    endcase
  endfunction

  // Item with every field random; callers overwrite the fields that matter.
  function automatic shader_item_t random_item(input logic [1:0] op);
    shader_item_t it;
    it.operation = op;
    it.texel_address = 13'($urandom);
    it.texel_color = 24'($urandom);
    it.longitude_turn = 16'($urandom);
    it.latitude_turn = 16'($urandom);
    it.light_cosine = 10'($urandom);
    return it;
  endfunction

  function automatic void queue_write(input logic [1:0] op, input logic [12:0] addr,
                                      input logic [23:0] color);
    shader_item_t it;
    it = random_item(op);
    it.texel_address = addr;
    it.texel_color = color;
    if (op == dnms_pkg::OP_WRITE_DAY) day_written[addr] = 1'b1;
    else night_written[addr] = 1'b1;
    pending_items.push_back(it);
  endfunction

  function automatic int load_if_blank(input int unsigned addr);
    int loaded;
    loaded = 0;
    if (!day_written[addr]) begin
      queue_write(dnms_pkg::OP_WRITE_DAY, 13'(addr), 24'($urandom));
      loaded++;
    end
    if (!night_written[addr]) begin
      queue_write(dnms_pkg::OP_WRITE_NIGHT, 13'(addr), 24'($urandom));
      loaded++;
    end
    return loaded;
  endfunction

  // Queues a shade transaction, first loading any neighbor texel never written.
  // Returns the number of transactions queued.
  function automatic int queue_shade(input logic [15:0] lon, input logic signed [15:0] lat,
                                     input logic signed [9:0] cosine);
    shader_item_t it;
    footprint_t fp;
    int queued;
    fp = locate_texels(lon, lat);
    queued = load_if_blank(fp.a00) + load_if_blank(fp.a01) + load_if_blank(fp.a10)
           + load_if_blank(fp.a11);
    it = random_item(dnms_pkg::OP_SHADE);
    it.longitude_turn = lon;
    it.latitude_turn = lat;
    it.light_cosine = cosine;
    pending_items.push_back(it);
    return queued + 1;
  endfunction

  function automatic void queue_unknown();
    pending_items.push_back(random_item(OP_UNKNOWN));
  endfunction

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_register(input logic [2:0] index, input int unsigned value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (index)
      dnms_pkg::REG_USE_NIGHT: cfg_use_night = value[0];
      dnms_pkg::REG_DAWN_WIDTH: cfg_dawn = value[8:0];
      dnms_pkg::REG_AMBIENT: cfg_amb = value[8:0];
      dnms_pkg::REG_MAP_WIDTH: cfg_width = value[7:0];
      dnms_pkg::REG_MAP_HEIGHT: cfg_height = value[6:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int unsigned use_night, input int unsigned dawn,
                                input int unsigned amb, input int unsigned width,
                                input int unsigned height);
    write_register(dnms_pkg::REG_USE_NIGHT, use_night);
    write_register(dnms_pkg::REG_DAWN_WIDTH, dawn);
    write_register(dnms_pkg::REG_AMBIENT, amb);
    write_register(dnms_pkg::REG_MAP_WIDTH, width);
    write_register(dnms_pkg::REG_MAP_HEIGHT, height);
  endtask

  // Waits until every transaction is sent and every pixel has arrived, then lets
  // writes still in the pipeline settle.
  task automatic wait_until_drained();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_random_phase(input int unsigned use_night, input int unsigned dawn,
                                  input int unsigned amb, input int unsigned width,
                                  input int unsigned height, input int unsigned mode,
                                  input bit with_hold);
    int produced, pick, cells;
    logic [15:0] lon;
    logic signed [15:0] lat;
    logic signed [9:0] cosine;
    apply_settings(use_night, dawn, amb, width, height);
    case (mode)
      1: begin send_idle_pct = 62; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 62; end
      3: begin send_idle_pct = 37; recv_stall_pct = 37; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
    cells = map_cols() * map_rows();
    produced = 0;
    while (produced < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        queue_unknown();
      end else if (pick < 30) begin
        // Half the writes refresh the map in use, half go anywhere in the store.
        queue_write($urandom_range(1) ? dnms_pkg::OP_WRITE_NIGHT : dnms_pkg::OP_WRITE_DAY,
                    13'($urandom_range(1) ? $urandom_range(cells - 1) : $urandom),
                    24'($urandom));
        produced++;
      end else begin
        lon = ($urandom_range(19) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
                                        : 16'($urandom);
        lat = ($urandom_range(99) < 85) ? 16'(int'($urandom_range(32768)) - 16384)
                                        : 16'($urandom);
        cosine = ($urandom_range(99) < 80) ? 10'(int'($urandom_range(512)) - 256)
                                           : 10'($urandom);
        produced += queue_shade(lon, lat, cosine);
      end
    end
    // Long receiver hold-off while the sender keeps offering transactions.
    if (with_hold) begin
      @(negedge clk_i);
      receiver_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      @(negedge clk_i);
      receiver_hold = 1'b0;
    end
    wait_until_drained();
  endtask

  // Driver: offers queued transactions, with random gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) absorb_item(offered_item);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_item = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= offered_item.operation;
          s_axis_tdata <= {1'b0, offered_item.light_cosine, offered_item.latitude_turn,
                           offered_item.longitude_turn, offered_item.texel_color,
                           offered_item.texel_address};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest predicted pixel.
  always @(posedge clk_i) begin
    pixel_t want, got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.red = m_axis_tdata[7:0];
        got.green = m_axis_tdata[15:8];
        got.blue = m_axis_tdata[23:16];
        if (expected_pixels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("pixel %0d arrived with none expected: r=%02h g=%02h b=%02h",
                     pixel_count, got.red, got.green, got.blue);
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("pixel %0d mismatch: expected r=%02h g=%02h b=%02h, got r=%02h g=%02h b=%02h",
                       pixel_count, want.red, want.green, want.blue,
                       got.red, got.green, got.blue);
          end
        end
        pixel_count++;
      end
      m_axis_tready <= !receiver_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stimulus: directed cases first, then random phases over several settings.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Store extremes and an unknown operation under the reset settings.
    queue_write(dnms_pkg::OP_WRITE_DAY, 13'h1FFF, 24'hFFFFFF);
    queue_write(dnms_pkg::OP_WRITE_NIGHT, 13'h1FFF, 24'h000000);
    queue_write(dnms_pkg::OP_WRITE_DAY, 13'h0000, 24'h000000);
    queue_write(dnms_pkg::OP_WRITE_NIGHT, 13'h0000, 24'hFFFFFF);
    queue_unknown();
    wait_until_drained();

    // Night map blend: longitude and latitude edges, pole wrap, clamped inputs.
    apply_settings(1, 128, 128, 3, 2);
    void'(queue_shade(16'h0000, -16384, 256));
    void'(queue_shade(16'hFFFF, 16384, -256));
    void'(queue_shade(16'h8000, 0, 0));
    void'(queue_shade(16'h7FFF, 16383, 1));
    void'(queue_shade(16'h1234, -32768, 511));
    void'(queue_shade(16'hC000, 32767, -512));
    void'(queue_shade(16'h4000, -1, 128));
    wait_until_drained();

    // Ambient scaling of the day map, lit and unlit.
    apply_settings(0, 256, 64, 3, 2);
    void'(queue_shade(16'h2000, 8192, 256));
    void'(queue_shade(16'h9000, -8192, 0));
    void'(queue_shade(16'hE000, 100, -256));
    void'(queue_shade(16'h5555, -5000, 100));
    wait_until_drained();

    run_random_phase(0, 0, 0, 1, 1, 0, 1'b1);
    run_random_phase(0, 256, 256, 128, 2, 1, 1'b0);
    run_random_phase(1, 256, 511, 2, 64, 2, 1'b0);
    run_random_phase(1, 0, 300, 0, 127, 3, 1'b0);
    run_random_phase(0, 511, 256, 255, 0, 0, 1'b0);
    run_random_phase(1, $urandom_range(511), $urandom_range(511), $urandom_range(1, 16),
                     $urandom_range(1, 8), 1, 1'b0);
    run_random_phase(0, $urandom_range(511), $urandom_range(511), $urandom_range(1, 16),
                     $urandom_range(1, 8), 2, 1'b0);
    run_random_phase(1, 64, 128, $urandom_range(1, 16), $urandom_range(1, 8), 3, 1'b0);

    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
